### src/kst_pkg.sv
package kst_pkg;

    localparam int KMAX   = 16;
    localparam int VAL_W  = 32;
    localparam int RANK_W = 5;
    localparam int CNT_W  = $clog2(KMAX + 1);

    typedef enum logic {
        S_IDLE,
        S_UPDATE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic update;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic preload;
    } t_sts;

endpackage

### src/kst_ctrl.sv
module kst_ctrl import kst_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_out_valid  = r_out_valid;
        o_in_ready   = 1'b0;
        o_cmd.load   = 1'b0;
        o_cmd.update = 1'b0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                // take a word once the output slot is free or draining
                o_in_ready = !r_out_valid || i_out_ready;
                if (i_in_valid && o_in_ready) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_UPDATE;
                end
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                if (!i_sts.preload) begin
                    n_out_valid = 1'b1;
                end
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

### src/kst_datapath.sv
module kst_datapath import kst_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cmd                    i_cmd,
    output t_sts                    o_sts,
    input  logic signed [VAL_W-1:0] i_value,
    input  logic                    i_preload,
    input  logic                    i_cfg_we,
    input  logic [RANK_W-1:0]       i_cfg_wdata,
    output logic signed [VAL_W-1:0] o_kth_value,
    output logic                    o_have_k
);

    logic signed [VAL_W-1:0] r_val;
    logic                    r_pre;
    logic [RANK_W-1:0]       r_rank;
    logic [CNT_W-1:0]        r_cnt, n_cnt;
    logic signed [VAL_W-1:0] r_cell [KMAX];
    logic signed [VAL_W-1:0] n_cell [KMAX];
    logic signed [VAL_W-1:0] r_kth;
    logic                    r_have;

    logic [CNT_W-1:0]        w_k;
    logic [KMAX-1:0]         w_vld, w_gt, w_lt;
    logic                    w_ins, w_rep;

    // effective rank: zero reads as one, saturate at the row length
    always_comb begin
        if (r_rank == '0) begin
            w_k = CNT_W'(1);
        end else if (int'(r_rank) > KMAX) begin
            w_k = CNT_W'(KMAX);
        end else begin
            w_k = CNT_W'(r_rank);
        end
    end

    assign w_ins = (r_cnt < w_k);
    assign w_rep = !w_ins && (r_cnt != '0) && (r_val > r_cell[0]);
    assign n_cnt = w_ins ? r_cnt + CNT_W'(1) : r_cnt;

    for (genvar j = 0; j < KMAX; j++) begin : g_cell
        logic                    w_gt_prev, w_lt_next, w_tail;
        logic signed [VAL_W-1:0] w_prev, w_next;

        assign w_vld[j] = CNT_W'(j) < r_cnt;
        assign w_gt[j]  = w_vld[j] && (r_cell[j] > r_val);
        assign w_lt[j]  = w_vld[j] && (r_cell[j] < r_val);
        assign w_tail   = CNT_W'(j) == r_cnt;

        if (j == 0) begin : g_first
            assign w_gt_prev = 1'b0;
            assign w_prev    = r_val;
        end else begin : g_mid
            assign w_gt_prev = w_gt[j-1];
            assign w_prev    = r_cell[j-1];
        end

        if (j == KMAX - 1) begin : g_last
            assign w_lt_next = 1'b0;
            assign w_next    = r_val;
        end else begin : g_inner
            assign w_lt_next = w_lt[j+1];
            assign w_next    = r_cell[j+1];
        end

        always_comb begin
            n_cell[j] = r_cell[j];
            if (w_ins) begin
                // larger neighbors shift up one cell, value drops into the gap
                if (w_gt[j] || (!w_vld[j] && w_tail)) begin
                    n_cell[j] = w_gt_prev ? w_prev : r_val;
                end
            end else if (w_rep) begin
                // smallest leaves, smaller ones shift down, value lands in place
                if (w_lt_next) begin
                    n_cell[j] = w_next;
                end else if (w_lt[j]) begin
                    n_cell[j] = r_val;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_cmd.update) begin
                r_cell[j] <= n_cell[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_rank <= RANK_W'(1);
        end else begin
            if (i_cfg_we) begin
                r_rank <= i_cfg_wdata;
            end
            if (i_cmd.update) begin
                r_cnt <= n_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_val <= i_value;
            r_pre <= i_preload;
        end
        if (i_cmd.update) begin
            r_kth  <= n_cell[0];
            r_have <= (n_cnt >= w_k);
        end
    end

    assign o_sts.preload = r_pre;
    assign o_kth_value   = r_kth;
    assign o_have_k      = r_have;

endmodule

### src/kth_largest_stream_tracker_unit.sv
// kth largest tracker: keeps the k largest signed 32-bit values seen so far in
// a row of KMAX sorted cells (ascending, smallest in cell 0) and, after every
// normal word, reports the smallest kept value together with a flag that is
// high once k values are held. k comes from the rank register (0 acts as 1,
// values above KMAX act as KMAX); until k values are held every value is
// inserted, afterwards a value strictly above the smallest replaces it and
// anything else is dropped. Words with tuser set are preload values: they go
// into the store but produce no output word. Each word is captured first, then
// every cell compares against it in parallel and shifts or loads; the result
// sits in an output register until taken, and the next input word is taken
// once that register is empty or draining. Lowering the rank mid-stream keeps
// all values already held. The rank register must only be written while no
// word is in flight.
module kth_largest_stream_tracker_unit import kst_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // rank register write
    input  logic              i_cfg_we,
    input  logic [RANK_W-1:0] i_cfg_wdata,
    // input stream
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [VAL_W-1:0]  s_axis_tdata,  // [31:0] value
    input  logic              s_axis_tuser,  // [0] preload
    // result stream
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [VAL_W-1:0]  m_axis_tdata,  // [31:0] kth_value
    output logic              m_axis_tuser   // [0] have_k
);

    t_cmd w_cmd;
    t_sts w_sts;
    logic signed [VAL_W-1:0] w_kth;

    // sequencing: capture, update, hold result
    kst_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // sorted cell row, count, rank register and result register
    kst_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_value     (s_axis_tdata),
        .i_preload   (s_axis_tuser),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_kth_value (w_kth),
        .o_have_k    (m_axis_tuser)
    );

    assign m_axis_tdata = w_kth;

endmodule

### bench/kth_largest_result_checker.sv
`timescale 1ns / 100ps

module kth_largest_result_checker import kst_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [RANK_W-1:0] i_cfg_wdata,
    input  logic              i_s_tvalid,
    input  logic              i_s_tready,
    input  logic [VAL_W-1:0]  i_s_tdata,   // [31:0] value
    input  logic              i_s_tuser,   // [0] preload
    input  logic              i_m_tvalid,
    input  logic              i_m_tready,
    input  logic [VAL_W-1:0]  i_m_tdata,   // [31:0] kth_value
    input  logic              i_m_tuser,   // [0] have_k
    output int                o_fail_count,
    output int                o_pending
);

    typedef struct {
        logic [VAL_W-1:0] kth_value;
        logic             have_k;
    } t_kth_result;

    logic signed [VAL_W-1:0] kept_vals [KMAX];
    int                      kept_cnt     = 0;
    logic [RANK_W-1:0]       rank_reg     = 1;
    t_kth_result             kth_expected [$];
    int                      mismatch_cnt = 0;

    // rank 0 acts as 1, anything above the store depth as the depth
    function automatic int eff_rank();
        int k;
        k = int'(rank_reg);
        if (k == 0) k = 1;
        if (k > KMAX) k = KMAX;
        return k;
    endfunction

    // store kept ascending, smallest in entry 0
    task automatic predict_word(input logic signed [VAL_W-1:0] v, input logic pre);
        int          k;
        int          j;
        t_kth_result r;
        k = eff_rank();
        if (kept_cnt < k) begin
            j = kept_cnt;
            while (j > 0 && kept_vals[j-1] > v) begin
                kept_vals[j] = kept_vals[j-1];
                j--;
            end
            kept_vals[j] = v;
            kept_cnt++;
        end else if (kept_cnt > 0 && v > kept_vals[0]) begin
            j = 0;
            while (j + 1 < kept_cnt && kept_vals[j+1] < v) begin
                kept_vals[j] = kept_vals[j+1];
                j++;
            end
            kept_vals[j] = v;
        end
        if (!pre) begin
            r.kth_value = kept_vals[0];
            r.have_k    = (kept_cnt >= eff_rank());
            kth_expected.push_back(r);
        end
    endtask

    task automatic note_mismatch(input string what, input t_kth_result exp_r);
        if (mismatch_cnt < 10)
            $display("%0t: %s: expected kth_value %h have_k %b, got kth_value %h have_k %b",
                     $realtime, what, exp_r.kth_value, exp_r.have_k, i_m_tdata, i_m_tuser);
        mismatch_cnt++;
    endtask

    always @(posedge i_clk) begin
        t_kth_result exp_r;
        if (!i_rst_n) begin
            kept_cnt = 0;
            rank_reg = 1;
            kth_expected.delete();
        end else begin
            // results first: a word taken in this cycle cannot leave in it
            if (i_m_tvalid && i_m_tready) begin
                if (kth_expected.size() == 0) begin
                    exp_r.kth_value = 'x;
                    exp_r.have_k    = 1'bx;
                    note_mismatch("unexpected output word", exp_r);
                end else begin
                    exp_r = kth_expected.pop_front();
                    if (i_m_tdata !== exp_r.kth_value || i_m_tuser !== exp_r.have_k)
                        note_mismatch("output word mismatch", exp_r);
                end
            end
            if (i_cfg_we)
                rank_reg = i_cfg_wdata;
            if (i_s_tvalid && i_s_tready)
                predict_word(i_s_tdata, i_s_tuser);
        end
        o_fail_count <= mismatch_cnt;
        o_pending    <= kth_expected.size();
    end

endmodule

### bench/tb_kth_largest_stream_tracker_unit.sv
`timescale 1ns / 100ps

module tb_kth_largest_stream_tracker_unit;
    import kst_pkg::*;

    // how random values are shaped within a phase
    typedef enum int {
        VM_MIXED,
        VM_RISING,
        VM_FALLING
    } t_value_mode;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 6;
    localparam int NUM_PHASES   = 14;
    localparam int PHASE_WORDS  = 82;

    localparam logic [VAL_W-1:0] VAL_MIN = 32'h8000_0000;
    localparam logic [VAL_W-1:0] VAL_MAX = 32'h7fff_ffff;

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              i_cfg_we      = 1'b0;
    logic [RANK_W-1:0] i_cfg_wdata   = '0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [VAL_W-1:0]  s_axis_tdata  = '0;  // [31:0] value
    logic              s_axis_tuser  = 1'b0; // [0] preload
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [VAL_W-1:0]  m_axis_tdata;        // [31:0] kth_value
    logic              m_axis_tuser;        // [0] have_k

    int fail_count;
    int pending;
    int cycle_count = 0;
    bit no_idle     = 1'b0;  // set for stretches with back-to-back traffic

    // rank per random phase: rising first so the store grows through
    // partially filled states, then the extremes and lowered ranks
    int phase_rank [NUM_PHASES] = '{4, 7, 10, 13, 16, 31, 1, 0, 20, 9, 16, 3, 2, 25};

    kth_largest_stream_tracker_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    kth_largest_result_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_s_tuser    (s_axis_tuser),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_m_tuser    (m_axis_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 20 ns clock
    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** kth_largest_stream_tracker_unit: FAILED **");
            $finish;
        end
    end

    // idle length: mostly none or short, now and then long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // result side: ready in runs, dropped for random stalls
    initial begin
        int run;
        int hold;
        @(posedge i_clk);
        forever begin
            run = $urandom_range(1, 24);
            m_axis_tready <= 1'b1;
            repeat (run) @(posedge i_clk);
            hold = no_idle ? 0 : gap_len();
            if (hold > 0) begin
                m_axis_tready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
        end
    end

    // present one word, hold it until taken, then maybe idle
    task automatic send_word(input logic [VAL_W-1:0] v, input logic pre);
        int g;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= v;
        s_axis_tuser  <= pre;
        do @(posedge i_clk); while (!s_axis_tready);
        g = no_idle ? 0 : gap_len();
        if (g > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    // stop sending and let every result drain; a preload word gives no
    // result, so an extra DRAIN_CYCLES wait covers one still in the cells
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // rank write, only called with the block idle
    task automatic write_rank(input int k);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= RANK_W'(k);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // near values collide often, so equal-to-smallest drops get exercised
    function automatic logic [VAL_W-1:0] pick_value(input t_value_mode mode,
                                                    input logic [VAL_W-1:0] base,
                                                    input logic [VAL_W-1:0] step,
                                                    input int idx);
        int r;
        r = $urandom_range(0, 99);
        if (mode != VM_MIXED && r < 75) begin
            if (mode == VM_RISING) return base + step * idx;
            return base - step * idx;
        end
        r = $urandom_range(0, 99);
        if (r < 30) return VAL_W'($signed($urandom_range(0, 16)) - 8);
        if (r < 45) begin
            case ($urandom_range(0, 5))
                0: return VAL_MIN;
                1: return VAL_MAX;
                2: return VAL_MIN + 1;
                3: return VAL_MAX - 1;
                4: return '0;
                default: return '1;
            endcase
        end
        return $urandom();
    endfunction

    initial begin
        t_value_mode      mode;
        logic [VAL_W-1:0] base;
        logic [VAL_W-1:0] step;
        logic             pre;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ---- directed part ----
        // rank stays at its reset value of 1 here
        send_word('0, 1'b0);
        send_word(VAL_MIN, 1'b0);   // below the smallest, dropped
        send_word(VAL_MAX, 1'b0);   // replaces the smallest
        send_word(VAL_MAX, 1'b0);   // equal to the smallest, dropped
        send_word(VAL_MAX, 1'b1);   // preload, no word back

        write_rank(3);
        send_word('1, 1'b1);
        send_word(VAL_MIN, 1'b0);   // store becomes full
        send_word(VAL_MIN, 1'b0);   // equal, dropped
        send_word(32'd1, 1'b0);

        write_rank(5);
        send_word(32'd7, 1'b0);     // not yet k values held
        send_word(VAL_MIN + 1, 1'b1);
        send_word('1, 1'b0);

        // rank of zero acts as one, and is a lowered rank mid-stream
        write_rank(0);
        send_word(32'd2, 1'b0);
        send_word(VAL_MIN, 1'b0);
        send_word(VAL_MAX, 1'b0);

        write_rank(2);
        send_word(-32'sd5, 1'b0);
        send_word(32'd5, 1'b0);

        // ---- random phases ----
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            write_rank(phase_rank[ph]);
            no_idle = (ph == 5 || ph == 11);
            mode = t_value_mode'(ph % 3);
            base = $urandom();
            step = $urandom_range(1, 3000);
            for (int n = 0; n < PHASE_WORDS; n++) begin
                pre = ($urandom_range(0, 99) < 15);
                send_word(pick_value(mode, base, step, n), pre);
                // sender holds off until every result is back
                if (ph == 3 && n == PHASE_WORDS / 2)
                    drain_results();
            end
        end
        no_idle = 1'b0;

        drain_results();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("** kth_largest_stream_tracker_unit: PASSED **");
        end else begin
            $display("** kth_largest_stream_tracker_unit: FAILED **");
        end
        $finish;
    end

endmodule
